[rtl/core/ultrasonic_echo_ranger_defines.svh]
// assertion macros for the echo ranger core
// depends on nothing; included by the top level only
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication under reset
`define UER_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uer assertion failed");
// next-cycle implication under reset
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uer assertion failed");
`else
`define UER_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/uer_pkg.sv]
// shared types and constants of the echo ranger core
// no dependencies; used by uer_divider and ultrasonic_echo_ranger
package uer_pkg;

    localparam int COUNTER_HZ_DEF  = 1000000;
    localparam int NUM_SENSORS_DEF = 4;

    localparam int KIND_W   = 2;
    localparam int SENSOR_W = 2;
    localparam int TICKS_W  = 16;
    localparam int DIST_W   = 16;
    localparam int TEMP_W   = 10;

    localparam logic [TEMP_W-1:0] TEMP_RESET = 10'd260;

    // tick to microsecond scaling
    localparam int US_SCALE  = 1000;
    localparam int US_PROD_W = 26;
    // microsecond to millimetre scaling
    localparam int MM_SCALE  = 100000;
    localparam int MM_PROD_W = 33;

    // shared serial divider
    localparam int DVD_W  = 34;
    localparam int DVS_W  = 19;
    localparam int STEP_W = 6;

    // speed of sound in mm/s
    localparam int SPEED_BASE  = 331300;
    localparam int SPEED_SLOPE = 606;
    localparam int SLOPE_W     = 17;
    localparam int SPEED_W     = 19;
    localparam int HUMID_SCALE = 100000;
    localparam int HUMID_STEP  = 17;
    // speed stays in 331300..393112 for any 10-bit temperature, so speed/100000 is always 3
    localparam int HUMID_CORR  = (SPEED_BASE / HUMID_SCALE) * HUMID_STEP;

    // x/10 as (x*205)>>11, exact for x below 1029
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;
    localparam int TQ_W        = 18;
    localparam int TDEG_W      = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_TRIGGER  = 2'd0,
        KIND_ECHO     = 2'd1,
        KIND_OVERFLOW = 2'd2
    } uer_kind_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SENSOR_W-1:0] sensor;
        logic [TICKS_W-1:0]  capture_ticks;
    } uer_item_t;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_id;
        logic [DIST_W-1:0]   distance_mm;
        logic                overflowed;
    } uer_result_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } uer_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } uer_div_rsp_t;

endpackage

[rtl/core/uer_divider.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on uer_pkg; dividend is left-aligned so steps bits are consumed
module uer_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  uer_pkg::uer_div_req_t req,
    output uer_pkg::uer_div_rsp_t rsp
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [uer_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic [uer_pkg::DVS_W-1:0]    rem_reg, rem_next;
    logic [uer_pkg::DVD_W-1:0]    dvd_reg, dvd_next;
    logic [uer_pkg::DVS_W-1:0]    dvs_reg, dvs_next;

    logic [uer_pkg::DVS_W:0]      shifted;
    logic [uer_pkg::DVS_W:0]      diff;
    logic                         fits;

    assign shifted = {rem_reg, dvd_reg[uer_pkg::DVD_W-1]};
    assign fits    = (shifted >= {1'b0, dvs_reg});
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[uer_pkg::DVS_W-1:0] : shifted[uer_pkg::DVS_W-1:0];
            dvd_next = {dvd_reg[uer_pkg::DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == uer_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

[rtl/core/ultrasonic_echo_ranger.sv]
// ultrasonic time-of-flight ranger: one measurement at a time, result in millimetres
// trigger and first echo edge update the registered phase; ignored items are dropped;
// an overflow result appears in the cycle after its transfer; a closing echo edge yields
// its distance after the shared bit-serial divider runs (26 steps then 33 steps)
// throughput: one item per cycle except during the arithmetic sequence after a closing
// edge and while a result waits on result_ready, when item_ready is low
// reset (rst_n, async low): idle, sensor 0, temperature 26.0 C, no result pending
module ultrasonic_echo_ranger #(
    parameter int COUNTER_HZ  = uer_pkg::COUNTER_HZ_DEF,
    parameter int NUM_SENSORS = uer_pkg::NUM_SENSORS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input item channel
    input  logic                        item_valid,
    output logic                        item_ready,
    input  uer_pkg::uer_item_t          item,
    // result channel
    output logic                        result_valid,
    input  logic                        result_ready,
    output uer_pkg::uer_result_t        result,
    // temperature register, tenths of a degree
    input  logic                        cfg_we,
    input  logic [uer_pkg::TEMP_W-1:0]  cfg_wdata
);

`include "ultrasonic_echo_ranger_defines.svh"

    // ticks per millisecond divisor, never zero
    localparam int US_DIV_INT = ((COUNTER_HZ / 1000) == 0) ? 1 : (COUNTER_HZ / 1000);
    localparam logic [uer_pkg::DVS_W-1:0] US_DIV = uer_pkg::DVS_W'(US_DIV_INT);
    localparam logic [uer_pkg::SPEED_W-1:0] SPEED_OFS =
        uer_pkg::SPEED_W'(uer_pkg::SPEED_BASE - uer_pkg::HUMID_CORR);

    // echo phases plus the arithmetic sequence after the closing edge
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARMED,
        ST_TIMING,
        ST_START_US,   // kick off ticks*1000 / (COUNTER_HZ/1000), build sound speed
        ST_DIV_US,     // wait for microseconds
        ST_MUL_MM,     // us * 100000
        ST_START_MM,   // kick off division by sound speed
        ST_DIV_MM      // wait for distance
    } state_t;

    state_t                             state_reg, state_next;
    logic [uer_pkg::SENSOR_W-1:0]       sensor_reg, sensor_next;
    logic [uer_pkg::TEMP_W-1:0]         temp_reg, temp_next;
    logic                               res_valid_reg, res_valid_next;
    uer_pkg::uer_result_t               res_reg, res_next;

    // arithmetic payload
    logic [uer_pkg::US_PROD_W-1:0]      us_prod_reg, us_prod_next;
    logic [uer_pkg::TQ_W-1:0]           tq_reg, tq_next;
    logic [uer_pkg::SPEED_W-1:0]        speed_reg, speed_next;
    logic [uer_pkg::DIST_W-1:0]         us_reg, us_next;
    logic [uer_pkg::MM_PROD_W-1:0]      mm_prod_reg, mm_prod_next;

    logic                               idle_phase;
    logic                               out_free;
    logic                               take;
    logic [uer_pkg::TDEG_W-1:0]         temp_deg;
    logic [uer_pkg::SLOPE_W-1:0]        slope_term;
    logic [uer_pkg::DIST_W-1:0]         us_sat;
    logic [uer_pkg::DIST_W-1:0]         mm_sat;

    uer_pkg::uer_div_req_t              div_req;
    uer_pkg::uer_div_rsp_t              div_rsp;

    uer_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // items are taken only in an echo phase and only with the result slot free
    assign idle_phase = (state_reg == ST_IDLE) || (state_reg == ST_ARMED) ||
                        (state_reg == ST_TIMING);
    assign out_free   = !res_valid_reg || result_ready;
    assign item_ready = idle_phase && out_free;
    assign take       = item_valid && item_ready;

    // whole degrees from tenths, then 606 mm/s per degree
    assign temp_deg   = tq_reg[uer_pkg::DIV10_SHIFT +: uer_pkg::TDEG_W];
    assign slope_term = uer_pkg::SLOPE_W'(uer_pkg::SPEED_SLOPE) *
                        uer_pkg::SLOPE_W'(temp_deg);

    // microseconds saturate at 16 bits
    assign us_sat = (|div_rsp.quotient[uer_pkg::DVD_W-1:uer_pkg::DIST_W]) ?
                    '1 : div_rsp.quotient[uer_pkg::DIST_W-1:0];
    // halve the round trip, then saturate
    assign mm_sat = (|div_rsp.quotient[uer_pkg::DVD_W-1:uer_pkg::DIST_W+1]) ?
                    '1 : div_rsp.quotient[uer_pkg::DIST_W:1];

    // divider requests: dividends left-aligned, steps equal to their width
    always_comb
    begin
        div_req.start    = (state_reg == ST_START_US) || (state_reg == ST_START_MM);
        div_req.dividend = {us_prod_reg, (uer_pkg::DVD_W - uer_pkg::US_PROD_W)'(0)};
        div_req.divisor  = US_DIV;
        div_req.steps    = uer_pkg::STEP_W'(uer_pkg::US_PROD_W);
        if (state_reg == ST_START_MM)
        begin
            div_req.dividend = {mm_prod_reg, (uer_pkg::DVD_W - uer_pkg::MM_PROD_W)'(0)};
            div_req.divisor  = speed_reg;
            div_req.steps    = uer_pkg::STEP_W'(uer_pkg::MM_PROD_W);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sensor_next    = sensor_reg;
        temp_next      = cfg_we ? cfg_wdata : temp_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_next       = res_reg;
        us_prod_next   = us_prod_reg;
        tq_next        = tq_reg;
        speed_next     = speed_reg;
        us_next        = us_reg;
        mm_prod_next   = mm_prod_reg;

        unique case (state_reg)
            ST_IDLE, ST_ARMED, ST_TIMING:
            begin
                if (take)
                begin
                    unique case (uer_pkg::uer_kind_t'(item.kind))
                        uer_pkg::KIND_TRIGGER:
                        begin
                            // absent sensors are ignored; a new trigger restarts
                            if (32'(item.sensor) < NUM_SENSORS)
                            begin
                                sensor_next = item.sensor;
                                state_next  = ST_ARMED;
                            end
                        end
                        uer_pkg::KIND_ECHO:
                        begin
                            if (state_reg == ST_ARMED)
                            begin
                                state_next = ST_TIMING;
                            end
                            else if (state_reg == ST_TIMING)
                            begin
                                // closing edge: scale ticks and temperature
                                us_prod_next = uer_pkg::US_PROD_W'(item.capture_ticks) *
                                               uer_pkg::US_PROD_W'(uer_pkg::US_SCALE);
                                tq_next      = uer_pkg::TQ_W'(temp_reg) *
                                               uer_pkg::TQ_W'(uer_pkg::DIV10_MUL);
                                state_next   = ST_START_US;
                            end
                        end
                        uer_pkg::KIND_OVERFLOW:
                        begin
                            if (state_reg != ST_IDLE)
                            begin
                                res_next.sensor_id   = sensor_reg;
                                res_next.distance_mm = '0;
                                res_next.overflowed  = 1'b1;
                                res_valid_next       = 1'b1;
                                state_next           = ST_IDLE;
                            end
                        end
                        default:
                        begin
                            // unused kind, dropped
                        end
                    endcase
                end
            end
            ST_START_US:
            begin
                speed_next = SPEED_OFS + uer_pkg::SPEED_W'(slope_term);
                state_next = ST_DIV_US;
            end
            ST_DIV_US:
            begin
                if (div_rsp.done)
                begin
                    us_next    = us_sat;
                    state_next = ST_MUL_MM;
                end
            end
            ST_MUL_MM:
            begin
                mm_prod_next = uer_pkg::MM_PROD_W'(us_reg) *
                               uer_pkg::MM_PROD_W'(uer_pkg::MM_SCALE);
                state_next   = ST_START_MM;
            end
            ST_START_MM:
            begin
                state_next = ST_DIV_MM;
            end
            ST_DIV_MM:
            begin
                // zero microseconds gives a zero quotient on its own
                if (div_rsp.done)
                begin
                    res_next.sensor_id   = sensor_reg;
                    res_next.distance_mm = mm_sat;
                    res_next.overflowed  = 1'b0;
                    res_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, sensor, temperature and the result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sensor_reg    <= '0;
            temp_reg      <= uer_pkg::TEMP_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sensor_reg    <= sensor_next;
            temp_reg      <= temp_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        us_prod_reg <= us_prod_next;
        tq_reg      <= tq_next;
        speed_reg   <= speed_next;
        us_reg      <= us_next;
        mm_prod_reg <= mm_prod_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // no item transfer while the divider runs
    `UER_ASSERT_NOW(a_ready_not_busy, clk, rst_n, item_ready, !div_rsp.busy)
    // the divider only finishes while a division is awaited
    `UER_ASSERT_NOW(a_done_in_wait, clk, rst_n, div_rsp.done,
        (state_reg == ST_DIV_US) || (state_reg == ST_DIV_MM))
    // a start always leaves the divider busy
    `UER_ASSERT_NEXT(a_start_busy, clk, rst_n, div_req.start, div_rsp.busy)
    // overflow results carry zero distance
    `UER_ASSERT_NOW(a_ovf_zero, clk, rst_n, result_valid && result.overflowed,
        result.distance_mm == '0)

endmodule

[verif/tb_ultrasonic_echo_ranger.sv]
// self-checking testbench for the ultrasonic echo ranger, directed and random traffic
// depends on uer_pkg and ultrasonic_echo_ranger; predicts each distance from its own
// copy of the ranging state and temperature register
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranger;

    // dut configuration, matches the block defaults
    localparam int RANGE_COUNTER_HZ  = uer_pkg::COUNTER_HZ_DEF;
    localparam int RANGE_NUM_SENSORS = uer_pkg::NUM_SENSORS_DEF;

    // air model constants, mm/s
    localparam longint unsigned SOUND_BASE_MMS   = 331300;
    localparam longint unsigned SOUND_PER_DEGREE = 606;
    localparam longint unsigned HUMIDITY_DIV     = 100000;
    localparam longint unsigned HUMIDITY_STEP    = 17;
    localparam longint unsigned MM_PER_US_SCALE  = 100000;
    localparam longint unsigned DIST_MAX         = 65535;

    // kind code the block must ignore
    localparam logic [uer_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // run control
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 100;   // longest division run plus margin
    localparam int RANDOM_ITEMS = 475;   // per idling phase, four phases

    typedef enum logic [1:0] {
        ECHO_DISARMED = 2'd0,
        ECHO_ARMED    = 2'd1,
        ECHO_TIMING   = 2'd2
    } echo_phase_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // dut ports, all driven to known values from time zero
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    uer_pkg::uer_item_t   item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    uer_pkg::uer_result_t result;
    logic                 cfg_we = 1'b0;
    logic [uer_pkg::TEMP_W-1:0] cfg_wdata = '0;

    ultrasonic_echo_ranger #(
        .COUNTER_HZ  (RANGE_COUNTER_HZ),
        .NUM_SENSORS (RANGE_NUM_SENSORS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // predictor state, mirrors the block after reset
    echo_phase_t                  echo_state   = ECHO_DISARMED;
    logic [uer_pkg::SENSOR_W-1:0] armed_sensor = '0;
    logic [uer_pkg::TEMP_W-1:0]   temp_tenths  = uer_pkg::TEMP_RESET;

    // expected measurements, oldest first
    uer_pkg::uer_result_t pending_ranges[$];

    // idling knobs, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // bookkeeping
    int unsigned error_count     = 0;
    int unsigned items_accepted  = 0;
    int unsigned ranges_checked  = 0;
    int unsigned overflow_ranges = 0;
    int unsigned zero_ranges     = 0;
    int unsigned cycle_count     = 0;
    logic [uer_pkg::TEMP_W-1:0] temp_lowest  = uer_pkg::TEMP_RESET;
    logic [uer_pkg::TEMP_W-1:0] temp_highest = uer_pkg::TEMP_RESET;

    // ticks -> microseconds -> millimetres, every step truncated
    function automatic logic [uer_pkg::DIST_W-1:0] distance_from_ticks(
        input logic [uer_pkg::TICKS_W-1:0] ticks,
        input logic [uer_pkg::TEMP_W-1:0]  tenths
    );
        longint unsigned tick_div;
        longint unsigned us;
        longint unsigned speed;
        longint unsigned half_path;
        tick_div = longint'(RANGE_COUNTER_HZ) / 1000;
        if (tick_div == 0)
            tick_div = 1;
        us = (64'(ticks) * 1000) / tick_div;
        if (us > DIST_MAX)
            us = DIST_MAX;
        if (us == 0)
            return '0;
        // speed of sound from whole degrees, then the fixed humidity correction
        speed = SOUND_BASE_MMS + SOUND_PER_DEGREE * (64'(tenths) / 10);
        speed = speed - (speed / HUMIDITY_DIV) * HUMIDITY_STEP;
        // round trip, so half the path
        half_path = ((us * MM_PER_US_SCALE) / speed) / 2;
        if (half_path > DIST_MAX)
            half_path = DIST_MAX;
        return half_path[uer_pkg::DIST_W-1:0];
    endfunction

    // advance the ranging state by one item, returns 1 when a measurement is due
    function automatic bit predict_ranging(input uer_pkg::uer_item_t it,
                                           output uer_pkg::uer_result_t meas);
        meas = '0;
        meas.sensor_id = armed_sensor;
        case (it.kind)
            uer_pkg::KIND_TRIGGER:
            begin
                if (it.sensor < RANGE_NUM_SENSORS)
                begin
                    armed_sensor = it.sensor;
                    echo_state   = ECHO_ARMED;
                end
                return 1'b0;
            end
            uer_pkg::KIND_ECHO:
            begin
                if (echo_state == ECHO_ARMED)
                begin
                    echo_state = ECHO_TIMING;
                    return 1'b0;
                end
                if (echo_state != ECHO_TIMING)
                    return 1'b0;
                meas.distance_mm = distance_from_ticks(it.capture_ticks, temp_tenths);
                meas.overflowed  = 1'b0;
                echo_state = ECHO_DISARMED;
                return 1'b1;
            end
            uer_pkg::KIND_OVERFLOW:
            begin
                if (echo_state == ECHO_DISARMED)
                    return 1'b0;
                meas.distance_mm = '0;
                meas.overflowed  = 1'b1;
                echo_state = ECHO_DISARMED;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic report_field(input string field, input int unsigned expv,
                                input int unsigned actv);
        if (expv != actv)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expv, actv);
            error_count++;
        end
    endtask

    // result check first, then prediction: a result never comes from the item
    // accepted at the same edge
    always @(posedge clk)
    begin
        uer_pkg::uer_result_t expected_range;
        uer_pkg::uer_result_t next_range;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_ranges.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, %s %0d %0d %0b",
                             $time, "actual sensor/dist/ovf", result.sensor_id,
                             result.distance_mm, result.overflowed);
                    error_count++;
                end
                else
                begin
                    expected_range = pending_ranges.pop_front();
                    report_field("sensor_id", expected_range.sensor_id, result.sensor_id);
                    report_field("distance_mm", expected_range.distance_mm,
                                 result.distance_mm);
                    report_field("overflowed", expected_range.overflowed, result.overflowed);
                    if (expected_range.overflowed)
                        overflow_ranges++;
                    else if (expected_range.distance_mm == 0)
                        zero_ranges++;
                end
                ranges_checked++;
            end
            if (item_valid && item_ready)
            begin
                items_accepted++;
                if (predict_ranging(item, next_range))
                    pending_ranges.push_back(next_range);
            end
        end
    end

    // receiver side, stalls at the current rate
    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_ranges.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic uer_pkg::uer_item_t make_item(
        input logic [uer_pkg::KIND_W-1:0]   k,
        input logic [uer_pkg::SENSOR_W-1:0] s,
        input logic [uer_pkg::TICKS_W-1:0]  t
    );
        uer_pkg::uer_item_t it;
        it.kind = k;
        it.sensor = s;
        it.capture_ticks = t;
        return it;
    endfunction

    // mix of edge values, short echoes and full-range captures
    function automatic logic [uer_pkg::TICKS_W-1:0] pick_ticks();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return '0;
        if (sel < 20)
            return '1;
        if (sel < 50)
            return uer_pkg::TICKS_W'($urandom_range(2000, 1));
        return uer_pkg::TICKS_W'($urandom);
    endfunction

    // one transfer on the item channel; called and returns just after a falling edge
    task automatic send_item(input uer_pkg::uer_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item = it;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    // all predicted results in, then let any ignored work settle
    task automatic wait_quiet();
        while (pending_ranges.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_temperature(input logic [uer_pkg::TEMP_W-1:0] tenths);
        wait_quiet();
        cfg_we = 1'b1;
        cfg_wdata = tenths;
        @(negedge clk);
        cfg_we = 1'b0;
        temp_tenths = tenths;
        if (tenths < temp_lowest)
            temp_lowest = tenths;
        if (tenths > temp_highest)
            temp_highest = tenths;
    endtask

    // trigger, opening edge, closing edge
    task automatic measure(input logic [uer_pkg::SENSOR_W-1:0] s,
                           input logic [uer_pkg::TICKS_W-1:0] t);
        send_item(make_item(uer_pkg::KIND_TRIGGER, s, uer_pkg::TICKS_W'($urandom)));
        send_item(make_item(uer_pkg::KIND_ECHO, uer_pkg::SENSOR_W'($urandom),
                            uer_pkg::TICKS_W'($urandom)));
        send_item(make_item(uer_pkg::KIND_ECHO, uer_pkg::SENSOR_W'($urandom), t));
    endtask

    // every kind, ignored items, zero and saturated times, overflow from both
    // active phases and retriggers, all at the reset temperature
    task automatic test_directed_cases();
        // nothing armed: echo, overflow and the unused kind are dropped
        send_item(make_item(uer_pkg::KIND_ECHO, 2'd1, 16'hffff));
        send_item(make_item(uer_pkg::KIND_OVERFLOW, 2'd2, 16'h0000));
        send_item(make_item(KIND_UNUSED, 2'd3, 16'h1234));
        // zero time gives zero distance
        measure(2'd0, 16'h0000);
        // longest capture
        measure(2'd3, 16'hffff);
        // shortest nonzero capture
        measure(2'd1, 16'h0001);
        // overflow while armed
        send_item(make_item(uer_pkg::KIND_TRIGGER, 2'd2, 16'h0000));
        send_item(make_item(uer_pkg::KIND_OVERFLOW, 2'd0, 16'hffff));
        // overflow while timing
        send_item(make_item(uer_pkg::KIND_TRIGGER, 2'd1, 16'hffff));
        send_item(make_item(uer_pkg::KIND_ECHO, 2'd0, 16'h0000));
        send_item(make_item(uer_pkg::KIND_OVERFLOW, 2'd3, 16'h0000));
        // retrigger while armed and again while timing, last sensor wins
        send_item(make_item(uer_pkg::KIND_TRIGGER, 2'd0, 16'h0000));
        send_item(make_item(uer_pkg::KIND_TRIGGER, 2'd2, 16'h0000));
        send_item(make_item(uer_pkg::KIND_ECHO, 2'd0, 16'h0000));
        send_item(make_item(uer_pkg::KIND_TRIGGER, 2'd3, 16'h0000));
        send_item(make_item(uer_pkg::KIND_ECHO, 2'd0, 16'h0000));
        send_item(make_item(uer_pkg::KIND_ECHO, 2'd0, 16'd1000));
    endtask

    // register extremes, cold and hot air, and back to the reset value
    task automatic test_temperature_extremes();
        logic [uer_pkg::TEMP_W-1:0] temps[5];
        temps = '{10'd0, 10'd1000, 10'd1023, 10'd9, uer_pkg::TEMP_RESET};
        foreach (temps[i])
        begin
            write_temperature(temps[i]);
            measure(uer_pkg::SENSOR_W'(i), 16'hffff);
            measure(uer_pkg::SENSOR_W'($urandom), pick_ticks());
        end
    endtask

    // mostly well-formed measurements, some aborted or restarted, plus noise
    task automatic test_random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned sel;
        sent = 0;
        while (sent < count)
        begin
            sel = $urandom_range(99);
            if (sel < 65)
            begin
                measure(uer_pkg::SENSOR_W'($urandom), pick_ticks());
                sent += 3;
            end
            else if (sel < 77)
            begin
                // aborted by counter overflow, from armed or timing
                send_item(make_item(uer_pkg::KIND_TRIGGER, uer_pkg::SENSOR_W'($urandom),
                                    uer_pkg::TICKS_W'($urandom)));
                if ($urandom_range(1))
                begin
                    send_item(make_item(uer_pkg::KIND_ECHO, uer_pkg::SENSOR_W'($urandom),
                                        uer_pkg::TICKS_W'($urandom)));
                    sent++;
                end
                send_item(make_item(uer_pkg::KIND_OVERFLOW, uer_pkg::SENSOR_W'($urandom),
                                    uer_pkg::TICKS_W'($urandom)));
                sent += 2;
            end
            else if (sel < 87)
            begin
                // restarted partway through
                send_item(make_item(uer_pkg::KIND_TRIGGER, uer_pkg::SENSOR_W'($urandom),
                                    uer_pkg::TICKS_W'($urandom)));
                send_item(make_item(uer_pkg::KIND_ECHO, uer_pkg::SENSOR_W'($urandom),
                                    uer_pkg::TICKS_W'($urandom)));
                measure(uer_pkg::SENSOR_W'($urandom), pick_ticks());
                sent += 5;
            end
            else
            begin
                // noise: any kind in any phase, not counted
                send_item(make_item(uer_pkg::KIND_W'($urandom_range(3)),
                                    uer_pkg::SENSOR_W'($urandom),
                                    uer_pkg::TICKS_W'($urandom)));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_temperature_extremes();

        // no idling
        write_temperature(uer_pkg::TEMP_W'($urandom_range(1000)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_traffic(RANDOM_ITEMS);

        // sparse sender
        write_temperature(uer_pkg::TEMP_W'($urandom));
        send_idle_pct = 85;
        recv_stall_pct = 0;
        test_random_traffic(RANDOM_ITEMS);

        // slow receiver
        write_temperature(uer_pkg::TEMP_W'($urandom_range(1000)));
        send_idle_pct = 0;
        recv_stall_pct = 85;
        test_random_traffic(RANDOM_ITEMS);

        // both sides idle
        write_temperature(uer_pkg::TEMP_W'($urandom));
        send_idle_pct = 29;
        recv_stall_pct = 29;
        test_random_traffic(RANDOM_ITEMS);

        wait_quiet();
        if (pending_ranges.size() != 0)
            error_count++;

        $display("run covered %0d item transfers and %0d measurements (%0d overflow, %0d zero)",
                 items_accepted, ranges_checked, overflow_ranges, zero_ranges);
        $display("temperature register swept from %0d to %0d tenths, %0d errors",
                 temp_lowest, temp_highest, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
